@@ hw/rtl/ir_pulse_distance_decoder_defines.svh @@
// Assertion macros shared by the IR pulse-distance decoder RTL.
`ifndef IR_PULSE_DISTANCE_DECODER_DEFINES_SVH
`define IR_PULSE_DISTANCE_DECODER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define IRPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define IRPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/irpd_pkg.sv @@
// Constants, types and threshold functions for the IR pulse-distance decoder.
package irpd_pkg;

    localparam int unsigned US_W       = 16;   // configured times in us
    localparam int unsigned CNT_W      = 8;    // measured lengths, bit counter
    localparam int unsigned FRAC_BITS  = 16;   // fixed-point scale of multipliers
    localparam int unsigned MARK_OFFSET = 100; // us taken off before the low mark bound
    localparam int unsigned MARK_LO_MUL = 1114;
    localparam int unsigned MARK_HI_MUL = 1507;
    localparam int unsigned PER_LO_MUL  = 1180;
    localparam int unsigned PER_HI_MUL  = 1442;
    localparam int unsigned BYTE_BITS   = 3;   // bit index low bits that select a byte slot

    localparam int unsigned MUL_W      = 11;          // multiplier constant width
    localparam int unsigned SUM_W      = US_W + 1;    // mark_us + space_us
    localparam int unsigned MPROD_W    = US_W + MUL_W;
    localparam int unsigned PPROD_W    = SUM_W + MUL_W;
    localparam int unsigned MTHR_W     = MPROD_W - FRAC_BITS;  // 11
    localparam int unsigned PTHR_W     = PPROD_W - FRAC_BITS;  // 12
    localparam int unsigned PERIOD_W   = CNT_W + 1;

    typedef enum logic [1:0] {
        REG_MARK_US       = 2'd0,
        REG_SPACE_ZERO_US = 2'd1,
        REG_SPACE_ONE_US  = 2'd2,
        REG_BIT_COUNT     = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [MTHR_W-1:0] lo;
        logic [MTHR_W-1:0] hi;
    } t_mark_win;

    typedef struct packed {
        logic [PTHR_W-1:0] lo;
        logic [PTHR_W-1:0] hi;
    } t_period_win;

    // Mark window; low bound is 0 for mark times under the offset.
    function automatic t_mark_win mark_win(input logic [US_W-1:0] x);
        logic [US_W-1:0]    diff;
        logic [MPROD_W-1:0] p_lo;
        logic [MPROD_W-1:0] p_hi;
        t_mark_win          w;
        diff = x - US_W'(MARK_OFFSET);
        p_lo = MPROD_W'(diff) * MPROD_W'(MARK_LO_MUL);
        p_hi = MPROD_W'(x) * MPROD_W'(MARK_HI_MUL);
        w.lo = (x < US_W'(MARK_OFFSET)) ? '0 : p_lo[MPROD_W-1:FRAC_BITS];
        w.hi = p_hi[MPROD_W-1:FRAC_BITS] + MTHR_W'(1);
        return w;
    endfunction

    function automatic t_period_win period_win(input logic [SUM_W-1:0] x);
        logic [PPROD_W-1:0] p_lo;
        logic [PPROD_W-1:0] p_hi;
        t_period_win        w;
        p_lo = PPROD_W'(x) * PPROD_W'(PER_LO_MUL);
        p_hi = PPROD_W'(x) * PPROD_W'(PER_HI_MUL);
        w.lo = p_lo[PPROD_W-1:FRAC_BITS];
        w.hi = p_hi[PPROD_W-1:FRAC_BITS] + PTHR_W'(1);
        return w;
    endfunction

endpackage

@@ hw/rtl/ir_pulse_distance_decoder.sv @@
// IR pulse-distance decoder: mark/space pairs in, decoded bytes out.
// Pairs pass through the input stage, classify logic and output register.
// Throughput: one pair per cycle, unless a pending result waits on m_axis_tready.
// Tolerance windows are registered from the config registers, so a write
// takes effect for pairs accepted from the edge after the write on.
// Synchronous active-low reset restores default timing and clears the frame.
`include "ir_pulse_distance_decoder_defines.svh"

module ir_pulse_distance_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // config write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [irpd_pkg::US_W-1:0]    i_cfg_data,
    // input requests
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [15:0]                  s_axis_tdata,   // [7:0] mark_len, [15:8] space_len
    // result requests
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,   // [7:0] data_byte
    output logic [0:0]                   m_axis_tuser,   // [0] error
    output logic                         m_axis_tlast
);

    localparam int unsigned CW = irpd_pkg::CNT_W;

    // ---------------- configuration ----------------
    logic [irpd_pkg::US_W-1:0] r_mark_us;
    logic [irpd_pkg::US_W-1:0] r_space0_us;
    logic [irpd_pkg::US_W-1:0] r_space1_us;
    logic [CW-1:0]             r_bit_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark_us   <= irpd_pkg::US_W'(560);
            r_space0_us <= irpd_pkg::US_W'(560);
            r_space1_us <= irpd_pkg::US_W'(1690);
            r_bit_count <= CW'(32);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                irpd_pkg::REG_MARK_US:       r_mark_us   <= i_cfg_data;
                irpd_pkg::REG_SPACE_ZERO_US: r_space0_us <= i_cfg_data;
                irpd_pkg::REG_SPACE_ONE_US:  r_space1_us <= i_cfg_data;
                irpd_pkg::REG_BIT_COUNT:     r_bit_count <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // Windows follow the config registers in the next cycle. One multiply per
    // bound, all in parallel, registered right after.
    irpd_pkg::t_mark_win   r_mark_win;
    irpd_pkg::t_period_win r_p0_win;
    irpd_pkg::t_period_win r_p1_win;

    always_ff @(posedge i_clk) begin
        r_mark_win <= irpd_pkg::mark_win(r_mark_us);
        r_p0_win   <= irpd_pkg::period_win({1'b0, r_mark_us} + {1'b0, r_space0_us});
        r_p1_win   <= irpd_pkg::period_win({1'b0, r_mark_us} + {1'b0, r_space1_us});
    end

    // ---------------- input stage ----------------
    logic          r_in_valid;
    logic [CW-1:0] r_mark_len;
    logic [CW-1:0] r_space_len;

    logic r_out_valid;
    logic [7:0] r_out_byte;
    logic r_out_err;
    logic r_out_last;

    logic emit;       // pair in the input stage produces a result
    logic advance;    // pair in the input stage retires this cycle

    // The stage drains when the pair makes no result or the output slot frees up.
    assign advance       = r_in_valid && (!emit || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_mark_len  <= s_axis_tdata[7:0];
            r_space_len <= s_axis_tdata[15:8];
        end
    end

    // ---------------- classify ----------------
    logic [irpd_pkg::PERIOD_W-1:0] period;
    logic [irpd_pkg::MTHR_W-1:0]   mark_ext;
    logic [irpd_pkg::PTHR_W-1:0]   period_ext;
    logic mark_ok, p0_ok, p1_ok, pair_ok, bit_val;

    assign period     = {1'b0, r_mark_len} + {1'b0, r_space_len};
    assign mark_ext   = irpd_pkg::MTHR_W'(r_mark_len);
    assign period_ext = irpd_pkg::PTHR_W'(period);
    assign mark_ok    = (mark_ext >= r_mark_win.lo) && (mark_ext <= r_mark_win.hi);
    assign p0_ok      = (period_ext >= r_p0_win.lo) && (period_ext <= r_p0_win.hi);
    assign p1_ok      = (period_ext >= r_p1_win.lo) && (period_ext <= r_p1_win.hi);
    assign pair_ok    = mark_ok && (p0_ok || p1_ok);
    assign bit_val    = !p0_ok;    // bit-0 window wins on overlap

    // ---------------- frame state ----------------
    logic [7:0]    r_bit_shift;
    logic [CW-1:0] r_bit_idx;
    logic [7:0]    n_bit_shift;
    logic [CW-1:0] n_bit_idx;
    logic [7:0]    shifted;
    logic [CW-1:0] idx_inc;
    logic          frame_end;

    assign shifted   = {r_bit_shift[6:0], bit_val};
    assign idx_inc   = r_bit_idx + CW'(1);          // bit count 0 means 256: wraps
    assign frame_end = (idx_inc == r_bit_count);
    assign emit      = !pair_ok || frame_end || (idx_inc[irpd_pkg::BYTE_BITS-1:0] == '0);

    always_comb begin
        if (!pair_ok) begin
            n_bit_shift = '0;
            n_bit_idx   = '0;
        end else begin
            n_bit_shift = emit ? 8'd0 : shifted;
            n_bit_idx   = frame_end ? '0 : idx_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_shift <= '0;
            r_bit_idx   <= '0;
        end else if (advance) begin
            r_bit_shift <= n_bit_shift;
            r_bit_idx   <= n_bit_idx;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_byte <= pair_ok ? shifted : 8'd0;
            r_out_err  <= !pair_ok;
            r_out_last <= !pair_ok || frame_end;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_byte;
    assign m_axis_tuser[0] = r_out_err;
    assign m_axis_tlast    = r_out_last;

    // ---------------- checks ----------------
    `IRPD_ASSERT(a_err_is_last, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == 8'd0, "error result must be last with zero data")
    `IRPD_ASSERT(a_err_restarts, advance && !pair_ok |=> r_bit_idx == '0 && r_bit_shift == 8'd0, "error must restart the frame")
    `IRPD_ASSERT(a_out_held, r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_out_byte) && $stable(r_out_last), "stalled result changed")
    `IRPD_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !m_axis_tvalid && !r_in_valid, "pipeline not empty after reset")

endmodule

@@ tb/ir_pulse_distance_decoder_test.sv @@
// Self-checking stream testbench for the IR pulse-distance decoder.
module ir_pulse_distance_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no request moved on any channel before the run is abandoned.
    localparam int unsigned STALL_LIMIT = 2000;
    // Random pairs to send after the directed part.
    localparam int unsigned RAND_TARGET = 950;
    // Settle time after the last result; covers the two-stage pipeline.
    localparam int unsigned SETTLE_CYCLES = 4;

    // One decoded result as seen on m_axis.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       error;
        logic       last;
    } t_decoded;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    ir_pulse_distance_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pairs waiting to be sent ({space_len, mark_len}) and decoded results
    // still owed by the block.
    logic [15:0] pair_q[$];
    t_decoded    decoded_q[$];

    // Decoder copy: timing setup and frame state, updated on accepted requests.
    logic [15:0] mark_time_us  = 16'd560;
    logic [15:0] zero_space_us = 16'd560;
    logic [15:0] one_space_us  = 16'd1690;
    logic [7:0]  frame_bits    = 8'd32;
    logic [7:0]  shift_acc     = '0;
    logic [7:0]  bit_pos       = '0;

    int unsigned send_idle_pct = 6;
    int unsigned recv_idle_pct = 78;
    int unsigned rand_pairs    = 0;
    int unsigned err_count     = 0;
    int unsigned stall_cycles  = 0;
    bit          in_taken      = 1'b0;

    // Mark window in 50 us ticks; lower bound drops to 0 for short marks.
    function automatic void win_mark(input int unsigned x, output int unsigned lo,
                                     output int unsigned hi);
        lo = (x >= irpd_pkg::MARK_OFFSET) ?
             ((x - irpd_pkg::MARK_OFFSET) * irpd_pkg::MARK_LO_MUL) >> irpd_pkg::FRAC_BITS
             : 0;
        hi = ((x * irpd_pkg::MARK_HI_MUL) >> irpd_pkg::FRAC_BITS) + 1;
    endfunction

    // Full-period window for a nominal mark+space time x in us.
    function automatic void win_period(input int unsigned x, output int unsigned lo,
                                       output int unsigned hi);
        lo = (x * irpd_pkg::PER_LO_MUL) >> irpd_pkg::FRAC_BITS;
        hi = ((x * irpd_pkg::PER_HI_MUL) >> irpd_pkg::FRAC_BITS) + 1;
    endfunction

    // Classifies one pair and advances the frame; returns 1 when a result is due.
    function automatic logic decode_pair(input logic [15:0] pair, output t_decoded res);
        int unsigned mlo, mhi, lo0, hi0, lo1, hi1, per;
        logic        bit_val;
        logic        bad;
        logic        frame_end;
        per = 32'(pair[7:0]) + 32'(pair[15:8]);
        win_mark(32'(mark_time_us), mlo, mhi);
        win_period(32'(mark_time_us) + 32'(zero_space_us), lo0, hi0);
        win_period(32'(mark_time_us) + 32'(one_space_us), lo1, hi1);
        res = '0;
        bad = 1'b0;
        bit_val = 1'b0;
        if (32'(pair[7:0]) < mlo || 32'(pair[7:0]) > mhi) begin
            bad = 1'b1;
        end else if (per >= lo0 && per <= hi0) begin
            bit_val = 1'b0;   // zero window wins where the two overlap
        end else if (per >= lo1 && per <= hi1) begin
            bit_val = 1'b1;
        end else begin
            bad = 1'b1;
        end
        if (bad) begin
            // any tolerance miss aborts the frame
            shift_acc = '0;
            bit_pos = '0;
            res.error = 1'b1;
            res.last = 1'b1;
            return 1'b1;
        end
        shift_acc = {shift_acc[6:0], bit_val};
        bit_pos = bit_pos + 8'd1;            // wraps, so a frame length of 0 means 256
        frame_end = (bit_pos == frame_bits);
        if (bit_pos[2:0] == 3'd0 || frame_end) begin
            res.data_byte = shift_acc;
            res.last = frame_end;
            shift_acc = '0;
            if (frame_end)
                bit_pos = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Half the time a window edge, otherwise anywhere inside.
    function automatic int unsigned pick_in(input int unsigned lo, input int unsigned hi);
        int unsigned r;
        r = $urandom_range(3);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return $urandom_range(hi, lo);
    endfunction

    // Builds a pair aimed at the given bit under the current timing; with miss
    // set, the mark or the period lands one tick outside its window.
    function automatic logic [15:0] make_pair(input bit want_one, input bit miss);
        int unsigned mlo, mhi, plo, phi, m, tlo, thi, tp, s;
        bit          miss_mark;
        win_mark(32'(mark_time_us), mlo, mhi);
        win_period(32'(mark_time_us) +
                   (want_one ? 32'(one_space_us) : 32'(zero_space_us)), plo, phi);
        if (mlo > 255)
            return 16'($urandom);
        if (mhi > 255)
            mhi = 255;
        miss_mark = miss && ($urandom_range(1) != 0);
        m = pick_in(mlo, mhi);
        if (miss_mark)
            m = (mlo > 0 && $urandom_range(1) != 0) ? mlo - 1 : mhi + 1;
        if (m > 255)
            m = 255;
        tlo = (plo > m) ? plo : m;
        thi = (phi < m + 255) ? phi : m + 255;
        if (tlo > thi)
            return 16'($urandom);
        tp = pick_in(tlo, thi);
        if (miss && !miss_mark)
            tp = (plo > 0 && $urandom_range(1) != 0) ? plo - 1 : phi + 1;
        s = (tp > m) ? tp - m : 0;
        if (s > 255)
            s = 255;
        return {8'(s), 8'(m)};
    endfunction

    function automatic void push_pair(input int unsigned mark_len, input int unsigned space_len);
        pair_q.push_back({8'(space_len), 8'(mark_len)});
    endfunction

    // Random pairs: mostly clean bits, some near misses, a few raw values; only clean bits with clean set.
    task automatic queue_pairs(input int unsigned n, input bit clean);
        int unsigned r;
        @(posedge i_clk);
        for (int unsigned k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (clean || r < 85)
                pair_q.push_back(make_pair($urandom_range(1) != 0, 1'b0));
            else if (r < 95)
                pair_q.push_back(make_pair($urandom_range(1) != 0, 1'b1));
            else
                pair_q.push_back(16'($urandom));
        end
        rand_pairs += n;
    endtask

    // Waits until every queued pair is sent and every owed result is in, then lets the pipe settle.
    task automatic drain();
        while (pair_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input irpd_pkg::t_cfg_reg reg_sel, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= reg_sel;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Sender: a new pair goes out once the previous one was taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (pair_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tdata  <= pair_q.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: tracks setup writes, predicts on accepted pairs, checks results.
    always @(posedge i_clk) begin : monitor
        t_decoded want;
        in_taken = s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            mark_time_us  = 16'd560;
            zero_space_us = 16'd560;
            one_space_us  = 16'd1690;
            frame_bits    = 8'd32;
            shift_acc     = '0;
            bit_pos       = '0;
            decoded_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (irpd_pkg::t_cfg_reg'(i_cfg_index))
                    irpd_pkg::REG_MARK_US:       mark_time_us  = i_cfg_data;
                    irpd_pkg::REG_SPACE_ZERO_US: zero_space_us = i_cfg_data;
                    irpd_pkg::REG_SPACE_ONE_US:  one_space_us  = i_cfg_data;
                    irpd_pkg::REG_BIT_COUNT:     frame_bits    = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_taken && decode_pair(s_axis_tdata, want))
                decoded_q.push_back(want);
            if (m_axis_tvalid && m_axis_tready) begin
                if (decoded_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result: data %h error %b last %b",
                                 m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
                end else begin
                    want = decoded_q.pop_front();
                    if (m_axis_tdata !== want.data_byte || m_axis_tuser[0] !== want.error ||
                        m_axis_tlast !== want.last) begin
                        err_count++;
                        // fields shown as data/error/last
                        if (err_count <= 10)
                            $display("result mismatch: expected %h/%b/%b, got %h/%b/%b",
                                     want.data_byte, want.error, want.last,
                                     m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
                    end
                end
            end
        end
        if (in_taken || (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
    end

    // Watchdog: nothing moving for too long means the block hung.
    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("ir_pulse_distance_decoder_test failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned phase;
        phase = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset timing: mark 7..13, zero period 20..25, one period 40..50.
        @(posedge i_clk);
        push_pair(0, 0);            // all-zero and all-one extremes, all rejected
        push_pair(255, 255);
        push_pair(0, 255);
        push_pair(255, 0);
        push_pair(6, 16);           // mark one tick short
        push_pair(14, 10);          // mark one tick long
        push_pair(7, 13);           // good zero bit, then the frame is aborted by
        push_pair(10, 20);          // a period falling between the two windows
        push_pair(13, 37);          // 0xA5, MSB first: a full byte inside the frame
        push_pair(10, 15);
        push_pair(7, 33);
        push_pair(10, 10);
        push_pair(8, 14);
        push_pair(10, 35);
        push_pair(12, 12);
        push_pair(9, 32);
        drain();

        // Short frame set below the current bit position: no result, the frame runs on.
        cfg_write(irpd_pkg::REG_BIT_COUNT, 16'd3);
        @(posedge i_clk);
        push_pair(10, 35);
        push_pair(10, 35);
        push_pair(10, 15);
        push_pair(10, 15);          // frame still open: the position is past the length
        push_pair(10, 35);
        drain();

        // Frame length cut below the current position: the frame runs on
        // until the bit counter wraps round to it.
        cfg_write(irpd_pkg::REG_BIT_COUNT, 16'd1);
        // Mark time below the offset: lower mark bound is zero.
        cfg_write(irpd_pkg::REG_MARK_US, 16'd50);
        @(posedge i_clk);
        push_pair(0, 12);
        push_pair(2, 30);
        push_pair(3, 10);           // over the short-mark upper bound
        drain();

        // Register extremes.
        cfg_write(irpd_pkg::REG_MARK_US, 16'd0);
        cfg_write(irpd_pkg::REG_SPACE_ZERO_US, 16'd0);
        cfg_write(irpd_pkg::REG_SPACE_ONE_US, 16'hFFFF);
        cfg_write(irpd_pkg::REG_BIT_COUNT, 16'd255);
        queue_pairs(12, 1'b0);
        drain();
        cfg_write(irpd_pkg::REG_MARK_US, 16'hFFFF);  // mark window beyond any 8-bit length
        queue_pairs(8, 1'b0);
        drain();
        cfg_write(irpd_pkg::REG_MARK_US, 16'd560);
        cfg_write(irpd_pkg::REG_SPACE_ZERO_US, 16'd560);
        cfg_write(irpd_pkg::REG_SPACE_ONE_US, 16'd1690);
        cfg_write(irpd_pkg::REG_BIT_COUNT, 16'd32);

        // Random phases; every change of setup happens with the pipe empty,
        // often with a frame half done.
        while (rand_pairs < RAND_TARGET) begin
            if (rand_pairs < RAND_TARGET / 3) begin
                send_idle_pct = 6;
                recv_idle_pct = 78;
            end else if (rand_pairs < 2 * RAND_TARGET / 3) begin
                send_idle_pct = 78;
                recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 3) begin
                // frame length 0 acts as 256 bits; clean bits so it can finish
                cfg_write(irpd_pkg::REG_BIT_COUNT, 16'd0);
                queue_pairs(300, 1'b1);
            end else begin
                if (phase != 0 && $urandom_range(99) < 60)
                    cfg_write(irpd_pkg::REG_MARK_US, ($urandom_range(9) == 0) ?
                              16'($urandom_range(99)) : 16'($urandom_range(3000, 100)));
                if (phase != 0 && $urandom_range(99) < 60)
                    cfg_write(irpd_pkg::REG_SPACE_ZERO_US, 16'($urandom_range(3000)));
                if (phase != 0 && $urandom_range(99) < 60)
                    cfg_write(irpd_pkg::REG_SPACE_ONE_US, 16'($urandom_range(8000)));
                if (phase == 2 || $urandom_range(99) < 60)
                    cfg_write(irpd_pkg::REG_BIT_COUNT, ($urandom_range(9) < 6) ?
                              16'($urandom_range(40, 1)) : 16'($urandom_range(255, 41)));
                queue_pairs($urandom_range(140, 60), 1'b0);
            end
            drain();
            phase++;
        end

        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0 && decoded_q.size() == 0)
            $display("ir_pulse_distance_decoder_test passed");
        else
            $display("ir_pulse_distance_decoder_test failed");
        $finish;
    end

endmodule
